// ===== rtl/core/ntri_pkg.sv =====
// Package for the nearest timestamp ring index block.
// Holds ring sizes, request codes, sequencer states and pointer helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ntri_pkg;

  localparam int ENTRIES = 512;
  localparam int PTR_W   = $clog2(ENTRIES);
  localparam int STAMP_W = 32;
  localparam int FRAME_W = 31;

  localparam logic [STAMP_W-1:0] HALF_RANGE = 32'h7FFF_FFFF;

  typedef logic [PTR_W-1:0] ptr_t;

  typedef enum logic [1:0] {
    REQ_PUT   = 2'd0,
    REQ_FIND  = 2'd1,
    REQ_CLEAR = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clear;
    logic vld;
  } dist_ctl_t;

  function automatic ptr_t ptr_next(input ptr_t p);
    ptr_t r;
    r = (p == PTR_W'(ENTRIES - 1)) ? '0 : p + PTR_W'(1);
    return r;
  endfunction

  function automatic ptr_t ptr_prev(input ptr_t p);
    ptr_t r;
    r = (p == '0) ? PTR_W'(ENTRIES - 1) : p - PTR_W'(1);
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ntri_ram.sv =====
// Simple dual-port RAM, one write and one registered read port.
// Generic; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module ntri_ram #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 63,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output      logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ntri_dist.sv =====
// Distance and compare unit: folded timestamp distance, then best-so-far.
// Two stages; depends on ntri_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ntri_dist (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire ntri_pkg::dist_ctl_t          ctl,
  input  wire logic [ntri_pkg::STAMP_W-1:0] query,
  input  wire logic [ntri_pkg::STAMP_W-1:0] stamp,
  input  wire logic [ntri_pkg::FRAME_W-1:0] frame,
  output      logic                         busy,
  output      logic [ntri_pkg::FRAME_W-1:0] best_index
);

  logic [ntri_pkg::STAMP_W-1:0] diff;
  logic [ntri_pkg::STAMP_W-1:0] fold;
  logic [ntri_pkg::STAMP_W-1:0] cur_dist;
  logic [ntri_pkg::FRAME_W-1:0] dist_frame;
  logic                         dist_vld;
  logic [ntri_pkg::STAMP_W-1:0] best_dist;

  always_comb begin
    diff = (stamp < query) ? (query - stamp) : (stamp - query);
    fold = (diff > ntri_pkg::HALF_RANGE) ? ~diff : diff;
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      dist_vld <= 1'b0;
    end else begin
      dist_vld <= ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    cur_dist   <= fold;
    dist_frame <= frame;
  end

  // strict compare: on a tie the earlier (newer) entry stays
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      best_dist  <= '1;
      best_index <= '0;
    end else if (dist_vld && (cur_dist < best_dist)) begin
      best_dist  <= cur_dist;
      best_index <= dist_frame;
    end
  end

  assign busy = dist_vld;

endmodule

`default_nettype wire

// ===== rtl/core/nearest_timestamp_ring_index.sv =====
// Top level of the nearest timestamp ring index.
// Depends on ntri_pkg, ntri_ram and ntri_dist.
//
// Input stream: s_tuser carries the request (put, find, clear), s_tdata the
// timestamp and frame index. A put stores the pair in the ring and drops
// the oldest pair when the ring fills; a clear empties the ring. Neither gives
// an item. A find gives one item on the output stream: the frame index whose
// timestamp is nearest the query, newest winning ties, or the last found
// index with the empty flag set when the ring is empty. A find walks the ring
// newest to oldest, one RAM read per cycle; an empty find skips the walk.
// s_tready is low while a find runs. The result sits in an output register;
// puts and clears are still taken while it is held, but a finished find
// waits with s_tready low until the register frees. Reset empties the ring
// and zeroes the last found index; RAM contents are not cleared and need
// no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module nearest_timestamp_ring_index (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [63:0] s_tdata,   // [31:0] pts, [62:32] frame_index, [63] zero
  input  wire logic [1:0]  s_tuser,   // [1:0] req_type
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [31:0] m_tdata,   // [30:0] found_index, [31] zero
  output      logic [0:0]  m_tuser    // [0] was_empty
);

  localparam int RAM_W = ntri_pkg::STAMP_W + ntri_pkg::FRAME_W;

  ntri_pkg::state_t    state;
  ntri_pkg::state_t    state_next;
  ntri_pkg::req_t      req;
  ntri_pkg::ptr_t      write_ptr;
  ntri_pkg::ptr_t      oldest_ptr;
  ntri_pkg::ptr_t      scan_ptr;
  ntri_pkg::ptr_t      put_next;
  ntri_pkg::dist_ctl_t dist_ctl;

  logic                         s_acc;
  logic                         ring_empty;
  logic                         ram_re;
  logic                         rd_vld;
  logic                         dist_busy;
  logic                         out_free;
  logic                         out_load;
  logic                         res_empty;
  logic [ntri_pkg::STAMP_W-1:0] query;
  logic [ntri_pkg::STAMP_W-1:0] in_pts;
  logic [ntri_pkg::FRAME_W-1:0] in_frame;
  logic [ntri_pkg::FRAME_W-1:0] last_found;
  logic [ntri_pkg::FRAME_W-1:0] best_index;
  logic [ntri_pkg::FRAME_W-1:0] found_index;
  logic                         was_empty;
  logic [RAM_W-1:0]             rd_data;

  assign req        = ntri_pkg::req_t'(s_tuser);
  assign in_pts     = s_tdata[31:0];
  assign in_frame   = s_tdata[62:32];
  assign s_acc      = s_tvalid && s_tready;
  assign ring_empty = (write_ptr == oldest_ptr);
  assign put_next   = ntri_pkg::ptr_next(write_ptr);
  assign out_free   = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    unique case (state)
      ntri_pkg::ST_IDLE: begin
        if (s_acc && (req == ntri_pkg::REQ_FIND)) begin
          state_next = ring_empty ? ntri_pkg::ST_DONE : ntri_pkg::ST_SCAN;
        end
      end
      ntri_pkg::ST_SCAN: begin
        if (scan_ptr == oldest_ptr) begin
          state_next = ntri_pkg::ST_DRAIN;
        end
      end
      ntri_pkg::ST_DRAIN: begin
        if (!rd_vld && !dist_busy) begin
          state_next = ntri_pkg::ST_DONE;
        end
      end
      ntri_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = ntri_pkg::ST_IDLE;
        end
      end
      default: state_next = ntri_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready       = 1'b0;
    ram_re         = 1'b0;
    out_load       = 1'b0;
    dist_ctl.clear = 1'b0;
    dist_ctl.vld   = rd_vld;
    unique case (state)
      ntri_pkg::ST_IDLE: begin
        s_tready       = 1'b1;
        dist_ctl.clear = s_tvalid && (req == ntri_pkg::REQ_FIND);
      end
      ntri_pkg::ST_SCAN:  ram_re   = 1'b1;
      ntri_pkg::ST_DRAIN: ram_re   = 1'b0;
      ntri_pkg::ST_DONE:  out_load = out_free;
      default:            s_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ntri_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_ptr  <= '0;
      oldest_ptr <= '0;
    end else if (s_acc) begin
      case (req)
        ntri_pkg::REQ_PUT: begin
          write_ptr <= put_next;
          if (put_next == oldest_ptr) begin
            oldest_ptr <= ntri_pkg::ptr_next(oldest_ptr);
          end
        end
        ntri_pkg::REQ_CLEAR: begin
          write_ptr  <= '0;
          oldest_ptr <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc && (req == ntri_pkg::REQ_FIND)) begin
      query     <= in_pts;
      res_empty <= ring_empty;
      scan_ptr  <= ntri_pkg::ptr_prev(write_ptr);
    end else if (ram_re) begin
      scan_ptr <= ntri_pkg::ptr_prev(scan_ptr);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= ram_re;
    end
  end

  ntri_ram #(
    .DEPTH (ntri_pkg::ENTRIES),
    .WIDTH (RAM_W)
  ) u_ram (
    .clk   (clk),
    .we    (s_acc && (req == ntri_pkg::REQ_PUT)),
    .waddr (write_ptr),
    .wdata ({in_frame, in_pts}),
    .re    (ram_re),
    .raddr (scan_ptr),
    .rdata (rd_data)
  );

  ntri_dist u_dist (
    .clk        (clk),
    .rst        (rst),
    .ctl        (dist_ctl),
    .query      (query),
    .stamp      (rd_data[ntri_pkg::STAMP_W-1:0]),
    .frame      (rd_data[RAM_W-1:ntri_pkg::STAMP_W]),
    .busy       (dist_busy),
    .best_index (best_index)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      last_found <= '0;
    end else if (out_load && !res_empty) begin
      last_found <= best_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      found_index <= res_empty ? last_found : best_index;
      was_empty   <= res_empty;
    end
  end

  assign m_tdata = {1'b0, found_index};
  assign m_tuser = was_empty;

endmodule

`default_nettype wire
